>>> design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU cache tag lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int STAMP_W   = 32;
  localparam int WAY_OUT_W = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

>>> design/set_assoc_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// Tag store of a set-associative cache with 64-byte lines and LRU refill.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid_i / in_stall_o carry one byte address.
//   Result channel: out_valid_o / out_stall_i carry hit, way_used and the
//   running hit and miss totals after that request.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0: index_bits, 1: ways_in_use); write only while idle.
//   Each set is one row of a single-port tag memory with registered read.
//   A request passes the registered row read, ST_LOOKUP and ST_FINISH. On a
//   miss with N above 1, ST_SCAN comes between them, where the LRU victim
//   search walks the ways of the row one per cycle, N being ways_in_use held
//   to 1..MAX_WAYS. One request is in flight at a time.
//   After reset the memory is cleared one row per cycle over all rows, MAX_SETS
//   rounded down to a power of two (512 by default); in_stall_o stays high.
//   A stalled result is held; the next request may be accepted and looked
//   up meanwhile, but its result waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_lookup #(
  parameter int MAX_SETS   = 512,
  parameter int MAX_WAYS   = 8,
  parameter int LINE_BYTES = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [sacl_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [sacl_pkg::ADDR_W-1:0]       address_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   hit_o,
  output logic [sacl_pkg::WAY_OUT_W-1:0]         way_used_o,
  output logic [sacl_pkg::CNT_W-1:0]             hit_total_o,
  output logic [sacl_pkg::CNT_W-1:0]             miss_total_o
);

  import sacl_pkg::*;

  localparam int IDX_MAX  = $clog2(MAX_SETS + 1) - 1;
  localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
  localparam int ROWS     = 1 << IDX_MAX;
  localparam int ROW_AW   = (IDX_MAX > 0) ? IDX_MAX : 1;
  localparam int TAG_W    = ADDR_W - OFF_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W     = 5;

  localparam logic [CFG_W-1:0]  IB_MAX   = CFG_W'(IDX_MAX);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
  localparam logic [NW_W-1:0]   NW_MAX   = NW_W'(MAX_WAYS);

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef entry_t [MAX_WAYS-1:0] row_t;

  row_t tag_mem [ROWS];

  state_e state_q, state_d;

  logic [CFG_W-1:0]   index_bits_q;
  logic [CFG_W-1:0]   ways_in_use_q;
  logic [ROW_AW-1:0]  clr_cnt_q;
  logic [ROW_AW-1:0]  row_addr_q;
  logic [TAG_W-1:0]   tag_q;
  row_t               rdata_q;
  logic [WAY_W-1:0]   scan_q;
  logic [WAY_W-1:0]   way_q;
  logic [STAMP_W-1:0] best_q;
  logic               hit_q;
  logic               out_valid_q;
  logic               hit_out_q;
  logic [WAY_OUT_W-1:0] way_out_q;
  logic [CNT_W-1:0]   hit_cnt_q;
  logic [CNT_W-1:0]   miss_cnt_q;
  logic [STAMP_W-1:0] clock_q;

  logic [CFG_W-1:0]   ib;
  logic [NW_W-1:0]    nw;
  logic [WAY_W-1:0]   last_way;
  logic [ADDR_W-1:0]  set_full;
  logic [ADDR_W-1:0]  tag_full;
  logic [MAX_WAYS-1:0] hit_vec;
  logic               hit_any;
  logic [WAY_W-1:0]   hit_way;
  logic [STAMP_W-1:0] cand;
  logic [STAMP_W-1:0] new_stamp;
  row_t               upd_row;
  logic               out_free;
  logic               mem_re;
  logic               mem_we;
  logic [ROW_AW-1:0]  mem_waddr;
  row_t               mem_wdata;

  // effective geometry
  always_comb begin
    ib = (index_bits_q > IB_MAX) ? IB_MAX : index_bits_q;
    if (ways_in_use_q == '0) begin
      nw = NW_W'(1);
    end else if (NW_W'(ways_in_use_q) > NW_MAX) begin
      nw = NW_MAX;
    end else begin
      nw = NW_W'(ways_in_use_q);
    end
    last_way = WAY_W'(nw - NW_W'(1));
  end

  assign set_full = (address_i >> OFF_BITS) & ~({ADDR_W{1'b1}} << ib);
  assign tag_full = (address_i >> OFF_BITS) >> ib;

  // tag compare across the row
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w] = rdata_q[w].valid && (rdata_q[w].tag == tag_q) && (w < int'(nw));
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    hit_any = |hit_vec;
  end

  assign cand      = rdata_q[scan_q].stamp;
  assign new_stamp = clock_q + STAMP_W'(1);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    upd_row = rdata_q;
    upd_row[way_q].stamp = new_stamp;
    if (!hit_q) begin
      upd_row[way_q].valid = 1'b1;
      upd_row[way_q].tag   = tag_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LAST_ROW) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (hit_any || last_way == '0) state_d = ST_FINISH;
        else state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_q == last_way) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = row_addr_q;
    mem_wdata  = upd_row;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        mem_re     = in_valid_i;
      end
      ST_FINISH: begin
        mem_we = out_free;
      end
      default: begin
      end
    endcase
  end

  // tag memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= tag_mem[set_full[ROW_AW-1:0]];
    end
  end

  // request payload and victim search
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      row_addr_q <= set_full[ROW_AW-1:0];
      tag_q      <= tag_full[TAG_W-1:0];
    end
    if (state_q == ST_LOOKUP) begin
      hit_q  <= hit_any;
      way_q  <= hit_any ? hit_way : '0;
      best_q <= rdata_q[0].stamp;
      scan_q <= WAY_W'(1);
    end
    if (state_q == ST_SCAN) begin
      if (cand < best_q) begin
        best_q <= cand;
        way_q  <= scan_q;
      end
      scan_q <= scan_q + WAY_W'(1);
    end
    if (state_q == ST_FINISH && out_free) begin
      hit_out_q <= hit_q;
      way_out_q <= WAY_OUT_W'(way_q);
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      index_bits_q  <= '0;
      ways_in_use_q <= CFG_W'(1);
      out_valid_q   <= 1'b0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      clock_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i;
          CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
        clock_q     <= new_stamp;
        if (hit_q) hit_cnt_q  <= hit_cnt_q + CNT_W'(1);
        else       miss_cnt_q <= miss_cnt_q + CNT_W'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_out_q;
  assign way_used_o   = way_out_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

endmodule

`default_nettype wire

>>> design/sacl_checker.sv
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the cache tag lookup, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_stall_o,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire logic                              hit_o,
  input  wire logic [sacl_pkg::CNT_W-1:0]        hit_total_o,
  input  wire logic [sacl_pkg::CNT_W-1:0]        miss_total_o
);

  import sacl_pkg::*;

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous still in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(hit_o)))
    else $error("stalled result dropped or changed");

  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hit_total_o) |->
      (hit_total_o == $past(hit_total_o) + CNT_W'(1)) && $stable(miss_total_o)
      && out_valid_o && hit_o)
    else $error("hit total moved without a hit result");

  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(miss_total_o) |->
      (miss_total_o == $past(miss_total_o) + CNT_W'(1)) && $stable(hit_total_o)
      && out_valid_o && !hit_o)
    else $error("miss total moved without a miss result");

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .hit_o        (hit_o),
  .hit_total_o  (hit_total_o),
  .miss_total_o (miss_total_o)
);

`default_nettype wire
